### hdl/razct_pkg.sv
// ----------------------------------------------------------------------------
// razct_pkg
// Shared types, sizes and command codes for the range-add zero-count tree.
// ----------------------------------------------------------------------------
package razct_pkg;

    localparam int LEAVES     = 1024;
    localparam int LEAF_BITS  = $clog2(LEAVES);
    localparam int PADDED     = 1 << LEAF_BITS;
    localparam int NODE_AW    = LEAF_BITS + 1;
    localparam int NODE_SLOTS = 2 * PADDED;
    localparam int LR_W       = LEAF_BITS + 2;
    localparam int CNT_W      = LEAF_BITS + 1;
    localparam int ZC_W       = 11;
    localparam int VAL_W      = 64;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_COUNT = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [10:0]        range_low;
        logic [10:0]        range_high;
        logic signed [31:0] add_value;
        logic [9:0]         query_index;
    } req_t;

    typedef struct packed {
        logic signed [63:0] leaf_value;
        logic [10:0]        zero_count;
        logic               result_kind;
    } rsp_t;

    typedef enum logic [4:0] {
        UOP_IDLE,
        UOP_LOAD,
        UOP_CLR,
        UOP_ADD_RD_L,
        UOP_ADD_WR_L,
        UOP_ADD_RD_R,
        UOP_ADD_WR_R,
        UOP_ADD_SHIFT,
        UOP_Q_RD,
        UOP_Q_ACC,
        UOP_S_RDP,
        UOP_S_RDL,
        UOP_S_WRL,
        UOP_S_WRR,
        UOP_C_START,
        UOP_C_RD,
        UOP_C_CHK,
        UOP_RESP
    } uop_t;

    typedef struct packed {
        uop_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       span_empty;
        logic       q_out;
        logic       l_lt_r;
        logic       l_odd;
        logic       r_odd;
        logic       q_done;
        logic       sweep_last;
        logic       count_done;
        logic       clr_last;
    } dp_status_t;

endpackage

### hdl/range_add_zero_count_tree.sv
// ----------------------------------------------------------------------------
// range_add_zero_count_tree
// Segment tree of 64-bit leaves with range add, point query and zero count.
// ----------------------------------------------------------------------------
// After reset the node memory is cleared one entry a cycle and no request is
// taken until that ends. Everything then runs through a single node memory
// with one read and one write port, which sets the timing: a range add
// makes, per tree level, up to two read-modify-writes and a shift, and an
// empty span skips the tree walk; a point query reads and sums each node
// from the leaf up to the root; a zero count flushes all 1023 inner nodes
// and then reads n leaves. One request is in flight at a time; a finished
// response waits in its output register while the next request is taken.
// ----------------------------------------------------------------------------
module range_add_zero_count_tree
    import razct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    razct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    razct_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp       (rsp)
    );

endmodule

### hdl/razct_ctrl.sv
// ----------------------------------------------------------------------------
// razct_ctrl
// Sequencer: walks each request through the datapath one step at a time.
// ----------------------------------------------------------------------------
module razct_ctrl
    import razct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [19:0] {
        ST_INIT     = 20'h00001,
        ST_IDLE     = 20'h00002,
        ST_DISPATCH = 20'h00004,
        ST_A_CHK    = 20'h00008,
        ST_A_RDL    = 20'h00010,
        ST_A_WRL    = 20'h00020,
        ST_A_RCHK   = 20'h00040,
        ST_A_RDR    = 20'h00080,
        ST_A_WRR    = 20'h00100,
        ST_A_SHIFT  = 20'h00200,
        ST_Q_RD     = 20'h00400,
        ST_Q_ACC    = 20'h00800,
        ST_S_RDP    = 20'h01000,
        ST_S_RDL    = 20'h02000,
        ST_S_WRL    = 20'h04000,
        ST_S_WRR    = 20'h08000,
        ST_C_START  = 20'h10000,
        ST_C_RD     = 20'h20000,
        ST_C_CHK    = 20'h40000,
        ST_RESP     = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    uop_t   uop;

    always_comb
    begin
        state_next = state_reg;
        uop        = UOP_IDLE;
        unique case (state_reg)
            ST_INIT:
            begin
                uop = UOP_CLR;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    uop        = UOP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.kind)
                    ACT_ADD:   state_next = status.span_empty ? ST_IDLE : ST_A_CHK;
                    ACT_QUERY: state_next = status.q_out ? ST_RESP : ST_Q_RD;
                    ACT_COUNT: state_next = ST_S_RDP;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_A_CHK:
            begin
                if (!status.l_lt_r)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.l_odd)
                begin
                    state_next = ST_A_RDL;
                end
                else if (status.r_odd)
                begin
                    state_next = ST_A_RDR;
                end
                else
                begin
                    state_next = ST_A_SHIFT;
                end
            end
            ST_A_RDL:
            begin
                uop        = UOP_ADD_RD_L;
                state_next = ST_A_WRL;
            end
            ST_A_WRL:
            begin
                uop        = UOP_ADD_WR_L;
                state_next = ST_A_RCHK;
            end
            ST_A_RCHK:
            begin
                state_next = status.r_odd ? ST_A_RDR : ST_A_SHIFT;
            end
            ST_A_RDR:
            begin
                uop        = UOP_ADD_RD_R;
                state_next = ST_A_WRR;
            end
            ST_A_WRR:
            begin
                uop        = UOP_ADD_WR_R;
                state_next = ST_A_SHIFT;
            end
            ST_A_SHIFT:
            begin
                uop        = UOP_ADD_SHIFT;
                state_next = ST_A_CHK;
            end
            ST_Q_RD:
            begin
                uop        = UOP_Q_RD;
                state_next = ST_Q_ACC;
            end
            ST_Q_ACC:
            begin
                uop        = UOP_Q_ACC;
                state_next = status.q_done ? ST_RESP : ST_Q_RD;
            end
            ST_S_RDP:
            begin
                uop        = UOP_S_RDP;
                state_next = ST_S_RDL;
            end
            ST_S_RDL:
            begin
                uop        = UOP_S_RDL;
                state_next = ST_S_WRL;
            end
            ST_S_WRL:
            begin
                uop        = UOP_S_WRL;
                state_next = ST_S_WRR;
            end
            ST_S_WRR:
            begin
                uop        = UOP_S_WRR;
                state_next = status.sweep_last ? ST_C_START : ST_S_RDP;
            end
            ST_C_START:
            begin
                uop        = UOP_C_START;
                state_next = ST_C_CHK;
            end
            ST_C_RD:
            begin
                uop        = UOP_C_RD;
                state_next = ST_C_CHK;
            end
            ST_C_CHK:
            begin
                if (state_reg == ST_C_CHK && status.count_done)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_C_RD;
                end
                uop = UOP_C_CHK;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    uop        = UOP_RESP;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (uop == UOP_RESP)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd.uop   = uop;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

### hdl/razct_dp.sv
// ----------------------------------------------------------------------------
// razct_dp
// Datapath: node memory, walk pointers, accumulator, counters, result reg.
// ----------------------------------------------------------------------------
module razct_dp
    import razct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  logic        cfg_valid,
    input  logic [10:0] cfg_data,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output rsp_t        rsp
);

    // Heap layout, 1-based: root at 1, children 2x and 2x+1, leaf i at PADDED+i.
    logic [VAL_W-1:0] node_mem [0:NODE_SLOTS-1];
    logic [VAL_W-1:0] rd_reg;

    logic               mem_we;
    logic [NODE_AW-1:0] mem_wa;
    logic [NODE_AW-1:0] mem_ra;
    logic [VAL_W-1:0]   mem_wd;

    logic [NODE_AW-1:0]   clr_ptr_reg, clr_ptr_next;
    logic [10:0]          element_count_reg;
    logic [LR_W-1:0]      l_reg, l_next;
    logic [LR_W-1:0]      r_reg, r_next;
    logic [VAL_W-1:0]     amt_reg, amt_next;
    logic [NODE_AW-1:0]   qn_reg, qn_next;
    logic [VAL_W-1:0]     acc_reg, acc_next;
    logic [1:0]           kind_reg, kind_next;
    logic                 span_empty_reg, span_empty_next;
    logic                 q_out_reg, q_out_next;
    logic [LEAF_BITS-1:0] x_reg, x_next;
    logic [CNT_W-1:0]     ci_reg, ci_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [ZC_W-1:0]      cnt_reg, cnt_next;
    logic [VAL_W-1:0]     pend_reg, pend_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [LR_W-1:0]      hi_clip;
    logic [LR_W-1:0]      r_dec;

    assign hi_clip = (32'(req.range_high) > LEAVES) ? LR_W'(LEAVES) : LR_W'(req.range_high);
    assign r_dec   = r_reg - LR_W'(1);

    always_comb
    begin
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = '0;
        mem_ra          = '0;
        clr_ptr_next    = clr_ptr_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        amt_next        = amt_reg;
        qn_next         = qn_reg;
        acc_next        = acc_reg;
        kind_next       = kind_reg;
        span_empty_next = span_empty_reg;
        q_out_next      = q_out_reg;
        x_next          = x_reg;
        ci_next         = ci_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        rsp_next        = rsp_reg;
        case (cmd.uop)
            UOP_LOAD:
            begin
                kind_next       = req.action;
                l_next          = LR_W'(PADDED) + LR_W'(req.range_low);
                r_next          = LR_W'(PADDED) + hi_clip;
                span_empty_next = (LR_W'(req.range_low) >= hi_clip);
                amt_next        = VAL_W'(req.add_value);
                q_out_next      = (32'(req.query_index) >= LEAVES);
                qn_next         = NODE_AW'(PADDED) + NODE_AW'(req.query_index);
                acc_next        = '0;
                x_next          = LEAF_BITS'(1);
                ci_next         = '0;
                cnt_next        = '0;
                n_next          = (32'(element_count_reg) > LEAVES) ?
                                  CNT_W'(LEAVES) : CNT_W'(element_count_reg);
            end
            UOP_CLR:
            begin
                mem_we       = 1'b1;
                mem_wa       = clr_ptr_reg;
                clr_ptr_next = clr_ptr_reg + NODE_AW'(1);
            end
            UOP_ADD_RD_L:
            begin
                mem_ra = l_reg[NODE_AW-1:0];
            end
            UOP_ADD_WR_L:
            begin
                mem_we = 1'b1;
                mem_wa = l_reg[NODE_AW-1:0];
                mem_wd = rd_reg + amt_reg;
                l_next = l_reg + LR_W'(1);
            end
            UOP_ADD_RD_R:
            begin
                mem_ra = r_dec[NODE_AW-1:0];
            end
            UOP_ADD_WR_R:
            begin
                mem_we = 1'b1;
                mem_wa = r_dec[NODE_AW-1:0];
                mem_wd = rd_reg + amt_reg;
                r_next = r_dec;
            end
            UOP_ADD_SHIFT:
            begin
                l_next = l_reg >> 1;
                r_next = r_reg >> 1;
            end
            UOP_Q_RD:
            begin
                mem_ra  = qn_reg;
                qn_next = qn_reg >> 1;
            end
            UOP_Q_ACC:
            begin
                acc_next = acc_reg + rd_reg;
            end
            UOP_S_RDP:
            begin
                mem_ra = {1'b0, x_reg};
            end
            UOP_S_RDL:
            begin
                pend_next = rd_reg;
                mem_we    = 1'b1;
                mem_wa    = {1'b0, x_reg};
                mem_ra    = {x_reg, 1'b0};
            end
            UOP_S_WRL:
            begin
                mem_we = 1'b1;
                mem_wa = {x_reg, 1'b0};
                mem_wd = rd_reg + pend_reg;
                mem_ra = {x_reg, 1'b1};
            end
            UOP_S_WRR:
            begin
                mem_we = 1'b1;
                mem_wa = {x_reg, 1'b1};
                mem_wd = rd_reg + pend_reg;
                x_next = x_reg + LEAF_BITS'(1);
            end
            UOP_C_START:
            begin
                ci_next = '0;
            end
            UOP_C_RD:
            begin
                mem_ra  = NODE_AW'(PADDED) + NODE_AW'(ci_reg);
                ci_next = ci_reg + CNT_W'(1);
            end
            UOP_C_CHK:
            begin
                // first pass after C_START has no leaf read yet
                if (ci_reg != '0 && rd_reg == '0)
                begin
                    cnt_next = cnt_reg + ZC_W'(1);
                end
            end
            UOP_RESP:
            begin
                if (kind_reg == ACT_COUNT)
                begin
                    rsp_next.leaf_value  = '0;
                    rsp_next.zero_count  = cnt_reg;
                    rsp_next.result_kind = 1'b1;
                end
                else
                begin
                    rsp_next.leaf_value  = q_out_reg ? '0 : acc_reg;
                    rsp_next.zero_count  = '0;
                    rsp_next.result_kind = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_wa] <= mem_wd;
        end
        rd_reg <= node_mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg       <= '0;
            element_count_reg <= 11'd1024;
        end
        else
        begin
            clr_ptr_reg <= clr_ptr_next;
            if (cfg_valid)
            begin
                element_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg          <= l_next;
        r_reg          <= r_next;
        amt_reg        <= amt_next;
        qn_reg         <= qn_next;
        acc_reg        <= acc_next;
        kind_reg       <= kind_next;
        span_empty_reg <= span_empty_next;
        q_out_reg      <= q_out_next;
        x_reg          <= x_next;
        ci_reg         <= ci_next;
        n_reg          <= n_next;
        cnt_reg        <= cnt_next;
        pend_reg       <= pend_next;
        rsp_reg        <= rsp_next;
    end

    assign status.kind       = kind_reg;
    assign status.span_empty = span_empty_reg;
    assign status.q_out      = q_out_reg;
    assign status.l_lt_r     = (l_reg < r_reg);
    assign status.l_odd      = l_reg[0];
    assign status.r_odd      = r_reg[0];
    assign status.q_done     = (qn_reg == '0);
    assign status.sweep_last = (x_reg == LEAF_BITS'(PADDED - 1));
    assign status.count_done = (ci_reg == n_reg);
    assign status.clr_last   = (clr_ptr_reg == NODE_AW'(NODE_SLOTS - 1));

    assign rsp = rsp_reg;

endmodule

### tb/razct_checker.sv
// ----------------------------------------------------------------------------
// razct_checker
// Watches the request, response and register channels of the range-add
// zero-count tree, keeps its own copy of every leaf sum and of the count
// register, and compares each response with the oldest outstanding answer.
// ----------------------------------------------------------------------------
module razct_checker
    import razct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [10:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_LEAF  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    logic [63:0] leaf_sum [LEAVES];
    logic [10:0] count_limit;
    rsp_t        answers_due [$];
    int          mismatches;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Leaf value is the wrapped sum of every add covering it, wherever the
    // pending amounts currently sit inside the tree.
    task automatic apply_request(input req_t item);
        int          hi;
        int          n;
        int          zeros;
        logic [63:0] amount;
        rsp_t        answer;
        answer = '0;
        case (action_t'(item.action))
            ACT_ADD:
            begin
                amount = {{32{item.add_value[31]}}, item.add_value};
                hi = (item.range_high > LEAVES) ? LEAVES : int'(item.range_high);
                for (int i = int'(item.range_low); i < hi; i++)
                    leaf_sum[i] += amount;
            end
            ACT_QUERY:
            begin
                answer.leaf_value  = leaf_sum[item.query_index];
                answer.result_kind = KIND_LEAF;
                answers_due.push_back(answer);
            end
            ACT_COUNT:
            begin
                n = (count_limit > LEAVES) ? LEAVES : int'(count_limit);
                zeros = 0;
                for (int i = 0; i < n; i++)
                    if (leaf_sum[i] == '0)
                        zeros++;
                answer.zero_count  = 11'(zeros);
                answer.result_kind = KIND_COUNT;
                answers_due.push_back(answer);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_response(input rsp_t got);
        rsp_t want;
        if (answers_due.size() == 0)
        begin
            report_mismatch($sformatf("response with nothing outstanding: %h", got));
        end
        else
        begin
            want = answers_due.pop_front();
            if (got.result_kind !== want.result_kind)
                report_mismatch($sformatf("result_kind %0d, want %0d",
                                          got.result_kind, want.result_kind));
            if (got.leaf_value !== want.leaf_value)
                report_mismatch($sformatf("leaf_value %h, want %h",
                                          got.leaf_value, want.leaf_value));
            if (got.zero_count !== want.zero_count)
                report_mismatch($sformatf("zero_count %0d, want %0d",
                                          got.zero_count, want.zero_count));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEAVES; i++)
                leaf_sum[i] = '0;
            count_limit = 11'd1024;
            answers_due.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_limit = cfg_data;
            if (rsp_valid && !rsp_stall)
                check_response(rsp);
            if (req_valid && !req_stall)
                apply_request(req);
            fail_count <= mismatches;
            pending    <= answers_due.size();
        end
    end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the range-add zero-count tree with a directed opening and then
// phases of random requests, each phase under its own count register value.
// Adds are often later cancelled so that leaves return to zero and the zero
// count moves; responses are checked by razct_checker.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import razct_pkg::*;

    localparam int PERIOD        = 10;
    localparam int RANDOM_ITEMS  = 400;
    localparam int PHASES        = 6;
    localparam int SETTLE_CYCLES = 128;
    localparam int CYCLE_LIMIT   = 1_500_000;

    typedef struct packed {
        logic [10:0] lo;
        logic [10:0] hi;
        logic [31:0] amount;
    } undo_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    req_t        req       = '0;
    logic        rsp_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [10:0] cfg_data  = '0;
    logic        quiet     = 1'b0;
    logic        req_stall;
    logic        rsp_valid;
    logic        cfg_ready;
    rsp_t        rsp;
    int          fail_count;
    int          pending;
    int          cycles    = 0;

    range_add_zero_count_tree u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    razct_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : rsp_backpressure
        int pick;
        forever
        begin
            @(posedge clk);
            pick = $urandom_range(0, 9);
            if (!quiet && pick < 2)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (pick == 2)
            begin
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
        end
    end

    function automatic req_t make_item(input action_t act, input int lo, input int hi,
                                       input logic [31:0] amount, input int leaf);
        req_t item;
        item.action      = act;
        item.range_low   = 11'(lo);
        item.range_high  = 11'(hi);
        item.add_value   = amount;
        item.query_index = 10'(leaf);
        return item;
    endfunction

    function automatic logic [31:0] pick_amount();
        logic [31:0] amount;
        case ($urandom_range(0, 2))
            0:       amount = 32'($urandom_range(0, 6)) - 32'd3;
            1:       amount = $urandom;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       amount = 32'h7FFF_FFFF;
                    1:       amount = 32'h8000_0000;
                    2:       amount = 32'hFFFF_FFFF;
                    default: amount = 32'h0000_0001;
                endcase
            end
        endcase
        return amount;
    endfunction

    // Valid stays high between back-to-back requests; it is lowered only
    // for a gap or by drain.
    task automatic send_request(input req_t item);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count_limit(input logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        undo_t       undo_list [$];
        undo_t       entry;
        req_t        item;
        logic [10:0] limit_value;
        logic [31:0] amount;
        int          sent;
        int          pick;
        int          lo;
        int          hi;
        int          leaf;
        int          idx;
        int          last_lo;
        int          last_hi;

        last_lo = 0;
        last_hi = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening: reset state, clipping, empty spans, extremes
        send_request(make_item(ACT_COUNT, 0, 0, 32'h0, 0));
        send_request(make_item(ACT_QUERY, 0, 0, 32'h0, 0));
        send_request(make_item(ACT_QUERY, 2047, 2047, 32'hFFFF_FFFF, 1023));
        send_request(make_item(ACT_ADD, 0, 2047, 32'h7FFF_FFFF, 0));
        send_request(make_item(ACT_QUERY, 0, 0, 32'h0, 1023));
        send_request(make_item(ACT_ADD, 0, 1024, 32'h8000_0001, 1023));
        send_request(make_item(ACT_COUNT, 2047, 2047, 32'hFFFF_FFFF, 1023));
        send_request(make_item(ACT_ADD, 3, 700, 32'h8000_0000, 0));
        send_request(make_item(ACT_ADD, 3, 700, 32'h8000_0000, 0));
        send_request(make_item(ACT_QUERY, 0, 0, 32'h0, 3));
        send_request(make_item(ACT_QUERY, 0, 0, 32'h0, 699));
        send_request(make_item(ACT_QUERY, 0, 0, 32'h0, 700));
        send_request(make_item(ACT_ADD, 1024, 1024, 32'h1, 0));
        send_request(make_item(ACT_ADD, 5, 5, 32'h1, 0));
        send_request(make_item(ACT_ADD, 900, 10, 32'h1, 0));
        send_request(make_item(ACT_ADD, 2047, 2047, 32'hFFFF_FFFF, 0));
        send_request(make_item(ACT_ADD, 1024, 2047, 32'hFFFF_FFFF, 0));
        send_request(make_item(ACT_ADD, 1023, 1024, 32'hFFFF_FFFF, 0));
        send_request(make_item(ACT_QUERY, 0, 0, 32'h0, 1023));
        send_request(make_item(ACT_ADD, 0, 1, 32'h1, 0));
        send_request(make_item(ACT_QUERY, 2047, 2047, 32'hFFFF_FFFF, 0));
        send_request(make_item(ACT_NONE, 2047, 2047, 32'hFFFF_FFFF, 1023));
        send_request(make_item(ACT_QUERY, 2047, 2047, 32'hFFFF_FFFF, 2));
        send_request(make_item(ACT_COUNT, 0, 0, 32'h0, 0));

        sent = 0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       limit_value = 11'd0;
                1:       limit_value = 11'd1;
                2:       limit_value = 11'd2047;
                3:       limit_value = 11'($urandom_range(2, 1022));
                4:       limit_value = 11'd1023;
                default: limit_value = 11'd1024;
            endcase
            drain();
            write_count_limit(limit_value);
            if (phase == PHASES - 1)
                quiet <= 1'b1;

            while (sent < (phase + 1) * RANDOM_ITEMS / PHASES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    item = make_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom);
                    send_request(item);
                end
                else
                begin
                    if (pick < 9)
                    begin
                        item = make_item(ACT_COUNT, $urandom, $urandom, $urandom, $urandom);
                    end
                    else if (pick < 33)
                    begin
                        case ($urandom_range(0, 2))
                            0:       leaf = last_lo;
                            1:       leaf = last_hi - 1;
                            default: leaf = $urandom;
                        endcase
                        item = make_item(ACT_QUERY, $urandom, $urandom, $urandom, leaf);
                    end
                    else if (undo_list.size() > 0 && (pick < 55 || undo_list.size() > 32))
                    begin
                        idx   = $urandom_range(0, undo_list.size() - 1);
                        entry = undo_list[idx];
                        undo_list.delete(idx);
                        item = make_item(ACT_ADD, entry.lo, entry.hi, -entry.amount,
                                         $urandom);
                    end
                    else
                    begin
                        case ($urandom_range(0, 9))
                            0:
                            begin
                                lo = $urandom_range(0, 2047);
                                hi = $urandom_range(0, 2047);
                            end
                            1, 2, 3, 4:
                            begin
                                lo = $urandom_range(0, 63);
                                hi = lo + $urandom_range(0, 16);
                            end
                            5, 6, 7:
                            begin
                                lo = $urandom_range(0, 1023);
                                hi = lo + $urandom_range(1, 200);
                            end
                            8:
                            begin
                                lo = 0;
                                hi = ($urandom_range(0, 1) == 0) ? 1024 : 2047;
                            end
                            default:
                            begin
                                lo = $urandom_range(0, 1023);
                                hi = 1024;
                            end
                        endcase
                        amount = pick_amount();
                        if ($urandom_range(0, 2) != 0)
                            undo_list.push_back('{lo: 11'(lo), hi: 11'(hi), amount: amount});
                        if (lo < 1024 && lo < hi)
                        begin
                            last_lo = lo;
                            last_hi = (hi > 1024) ? 1024 : hi;
                        end
                        item = make_item(ACT_ADD, lo, hi, amount, $urandom);
                    end
                    send_request(item);
                    sent++;
                end
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
